/* rtl/anchor_box_decoder_core_macros.svh */
// Assertion macros shared by the anchor box decoder RTL.
// Each macro expects a clock named clk and a reset named rst in scope.
`ifndef ANCHOR_BOX_DECODER_CORE_MACROS_SVH
`define ANCHOR_BOX_DECODER_CORE_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define ABD_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define ABD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

// Next-cycle implication that is also checked while reset is high.
`define ABD_ASSERT_NEXT_ALWAYS(label, ante, cons, msg) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/abd_pkg.sv */
// Shared constants, types and elaboration-time functions of the anchor box decoder.
// Used by abd_lane, anchor_box_decoder_core and the testbench; depends on nothing else.
`timescale 1ns / 1ps
`default_nettype none

package abd_pkg;

  // Default number of index bits of the exp2 table.
  localparam int ABD_EXP_TABLE_BITS = 8;
  // Largest supported table index width.
  localparam int ABD_EXP_BITS_MAX = 12;

  // Number of register stages between the request port and the result port.
  localparam int ABD_STAGES = 9;

  // log2(e) in Q30.
  localparam logic [31:0] ABD_LOG2E_Q30 = 32'd1549082005;

  // Configuration register indexes.
  localparam int ABD_CFG_IDX_W = 2;
  localparam logic [ABD_CFG_IDX_W-1:0] ABD_REG_CENTER_VAR = 2'd0;
  localparam logic [ABD_CFG_IDX_W-1:0] ABD_REG_SIZE_VAR   = 2'd1;

  // Reset values of the configuration registers (Q0.16).
  localparam logic [15:0] ABD_CENTER_VAR_RESET = 16'd6554;
  localparam logic [15:0] ABD_SIZE_VAR_RESET   = 16'd13107;

  // Per-stage load enables from the pipeline control to the datapath lanes.
  typedef struct packed {
    logic [ABD_STAGES-1:0] load;
  } abd_ctrl_t;

  // Floor of the square root of a 64-bit value, bit by bit.
  function automatic longint unsigned abd_isqrt(input longint unsigned x);
    longint unsigned rem;
    longint unsigned res;
    longint unsigned bitv;
    rem  = x;
    res  = 64'd0;
    bitv = 64'h4000_0000_0000_0000;
    for (int k = 0; k < 32; k++) begin
      if (rem >= res + bitv) begin
        rem = rem - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  // Entry i of the exp2 table, 2^(i / 2^bits) in Q30, built from repeated
  // square roots of two and rounded half up after every product.
  function automatic longint unsigned abd_exp_entry(input int bits, input int i);
    longint unsigned roots [0:ABD_EXP_BITS_MAX];
    longint unsigned acc;
    roots[0] = 64'd1 << 31;
    for (int k = 1; k <= ABD_EXP_BITS_MAX; k++) begin
      if (k <= bits) begin
        roots[k] = abd_isqrt(roots[k-1] << 30);
      end else begin
        roots[k] = 64'd0;
      end
    end
    acc = 64'd1 << 30;
    for (int j = 0; j <= ABD_EXP_BITS_MAX; j++) begin
      if ((j <= bits) && (((i >> j) & 1) == 1)) begin
        acc = (acc * roots[bits - j] + (64'd1 << 29)) >> 30;
      end
    end
    return acc;
  endfunction

endpackage

`default_nettype wire

/* rtl/abd_lane.sv */
// One axis of the anchor box decoder: centre offset, exp2 scaling and corners.
// Depends on abd_pkg; its stage registers load under control of the top level.
`timescale 1ns / 1ps
`default_nettype none

module abd_lane
  import abd_pkg::*;
#(
  parameter int EXP_TABLE_BITS = ABD_EXP_TABLE_BITS
) (
  input  logic               clk,
  input  abd_ctrl_t          ctrl,
  input  logic [15:0]        center_variance,
  input  logic [15:0]        size_variance,
  input  logic               func,
  input  logic [15:0]        center,
  input  logic [15:0]        size,
  input  logic signed [15:0] delta,
  input  logic signed [15:0] delta_size,
  output logic signed [19:0] out_start,
  output logic signed [19:0] out_end,
  output logic               sat
);

  localparam int N   = 1 << EXP_TABLE_BITS;
  localparam int FRW = 30 - EXP_TABLE_BITS;
  localparam int IDX_TOP = 57;

  // Round a Q16 value to Q14 half away from zero, then clamp to 20 bits.
  // Bit 20 of the result is the clamp flag.
  function automatic logic [20:0] abd_finish(input logic signed [33:0] v);
    logic signed [34:0] sum;
    logic signed [32:0] r;
    logic [20:0]        res;
    sum = {v[33], v} + 35'sd2 - {34'd0, v[33]};
    r   = sum[34:2];
    if (r > 33'sd524287) begin
      res = {1'b1, 20'h7FFFF};
    end else if (r < -33'sd524288) begin
      res = {1'b1, 20'h80000};
    end else begin
      res = {1'b0, r[19:0]};
    end
    return res;
  endfunction

  // exp2 table, fixed at elaboration.
  logic [31:0] rom [0:N];
  for (genvar gi = 0; gi <= N; gi++) begin : g_rom
    localparam logic [31:0] ENTRY = 32'(abd_exp_entry(EXP_TABLE_BITS, gi));
    assign rom[gi] = ENTRY;
  end

  // Stage 1: delta times the variance registers.
  logic               s1_func;
  logic [15:0]        s1_center, s1_size;
  logic signed [32:0] s1_dc;
  logic signed [31:0] s1_t;
  logic signed [32:0] t_full;

  assign t_full = delta_size * $signed({1'b0, size_variance});

  always_ff @(posedge clk) begin
    if (ctrl.load[0]) begin
      s1_func   <= func;
      s1_center <= center;
      s1_size   <= size;
      s1_dc     <= delta * $signed({1'b0, center_variance});
      s1_t      <= t_full[31:0];
    end
  end

  // Stage 2: full centre offset product and the exponent in base two.
  logic               s2_func;
  logic [15:0]        s2_center, s2_size;
  logic signed [49:0] s2_off_prod;
  logic signed [63:0] s2_u_prod;

  always_ff @(posedge clk) begin
    if (ctrl.load[1]) begin
      s2_func     <= s1_func;
      s2_center   <= s1_center;
      s2_size     <= s1_size;
      s2_off_prod <= s1_dc * $signed({1'b0, s1_size});
      s2_u_prod   <= s1_t * $signed(ABD_LOG2E_Q30);
    end
  end

  // Stage 3: round the offset to Q16; split the exponent into integer part,
  // table index and interpolation fraction.
  logic                      s3_func;
  logic [15:0]               s3_center, s3_size;
  logic signed [23:0]        s3_off;
  logic [EXP_TABLE_BITS-1:0] s3_idx;
  logic [FRW-1:0]            s3_fr;
  logic [5:0]                s3_shamt;
  logic [49:0]               off_sum;
  logic [4:0]                exp_int;
  logic [6:0]                sh_full;

  assign off_sum = s2_off_prod + 50'sd33554432 - {49'd0, s2_off_prod[49]};
  assign exp_int = s2_u_prod[62:58];
  assign sh_full = 7'd28 - {{2{exp_int[4]}}, exp_int};

  always_ff @(posedge clk) begin
    if (ctrl.load[2]) begin
      s3_func   <= s2_func;
      s3_center <= s2_center;
      s3_size   <= s2_size;
      s3_off    <= off_sum[49:26];
      s3_idx    <= s2_u_prod[IDX_TOP -: EXP_TABLE_BITS];
      s3_fr     <= s2_u_prod[IDX_TOP-EXP_TABLE_BITS -: FRW];
      s3_shamt  <= sh_full[5:0];
    end
  end

  // Stage 4: centre point and the two neighboring table entries.
  logic                    s4_func;
  logic [15:0]             s4_size;
  logic signed [24:0]      s4_px;
  logic [31:0]             s4_t0, s4_diff;
  logic [FRW-1:0]          s4_fr;
  logic [5:0]              s4_shamt;
  logic [EXP_TABLE_BITS:0] idx_lo, idx_hi;
  logic [31:0]             t_lo, t_hi;

  assign idx_lo = {1'b0, s3_idx};
  assign idx_hi = idx_lo + (EXP_TABLE_BITS+1)'(1);
  assign t_lo   = rom[idx_lo];
  assign t_hi   = rom[idx_hi];

  always_ff @(posedge clk) begin
    if (ctrl.load[3]) begin
      s4_func  <= s3_func;
      s4_size  <= s3_size;
      s4_px    <= $signed({7'd0, s3_center, 2'b00}) + $signed({s3_off[23], s3_off});
      s4_t0    <= t_lo;
      s4_diff  <= t_hi - t_lo;
      s4_fr    <= s3_fr;
      s4_shamt <= s3_shamt;
    end
  end

  // Stage 5: linear interpolation between the table entries.
  logic               s5_func;
  logic [15:0]        s5_size;
  logic signed [24:0] s5_px;
  logic [31:0]        s5_m;
  logic [5:0]         s5_shamt;
  logic [31+FRW:0]    interp;

  assign interp = s4_diff * s4_fr;

  always_ff @(posedge clk) begin
    if (ctrl.load[4]) begin
      s5_func  <= s4_func;
      s5_size  <= s4_size;
      s5_px    <= s4_px;
      s5_m     <= s4_t0 + interp[31+FRW:FRW];
      s5_shamt <= s4_shamt;
    end
  end

  // Stage 6: anchor size times the mantissa.
  logic               s6_func;
  logic signed [24:0] s6_px;
  logic [47:0]        s6_prod;
  logic [5:0]         s6_shamt;

  always_ff @(posedge clk) begin
    if (ctrl.load[5]) begin
      s6_func  <= s5_func;
      s6_px    <= s5_px;
      s6_prod  <= s5_size * s5_m;
      s6_shamt <= s5_shamt;
    end
  end

  // Stage 7: apply the integer exponent and round the half size to Q16.
  logic               s7_func;
  logic signed [24:0] s7_px;
  logic [31:0]        s7_h;
  logic [47:0]        q;
  logic [32:0]        q_inc;

  assign q     = s6_prod >> s6_shamt;
  assign q_inc = {1'b0, q[31:0]} + 33'd1;

  always_ff @(posedge clk) begin
    if (ctrl.load[6]) begin
      s7_func <= s6_func;
      s7_px   <= s6_px;
      s7_h    <= q_inc[32:1];
    end
  end

  // Stage 8: corners; a landmark keeps the centre point and a zero end.
  logic               s8_func;
  logic signed [33:0] s8_start, s8_end;
  logic signed [33:0] px_ext;

  assign px_ext = {{9{s7_px[24]}}, s7_px};

  always_ff @(posedge clk) begin
    if (ctrl.load[7]) begin
      s8_func <= s7_func;
      if (s7_func) begin
        s8_start <= px_ext;
        s8_end   <= '0;
      end else begin
        s8_start <= px_ext - $signed({2'b00, s7_h});
        s8_end   <= px_ext + $signed({2'b00, s7_h});
      end
    end
  end

  // Stage 9: round to Q14 and clamp into the result registers.
  logic [20:0] fin_start, fin_end;

  assign fin_start = abd_finish(s8_start);
  assign fin_end   = abd_finish(s8_end);

  always_ff @(posedge clk) begin
    if (ctrl.load[8]) begin
      out_start <= fin_start[19:0];
      out_end   <= fin_end[19:0];
      sat       <= fin_start[20] | (fin_end[20] & ~s8_func);
    end
  end

endmodule

`default_nettype wire

/* rtl/anchor_box_decoder_core.sv */
// Top level of the anchor box decoder: request and result channels,
// configuration registers and pipeline control. Depends on abd_pkg, abd_lane
// and the assertion macros in anchor_box_decoder_core_macros.svh.
//
// Usage. A request carries one anchor (center and size, unsigned Q2.14) and
// four signed Q4.12 deltas. It is taken at a rising edge with in_valid high
// and in_stall low. With func low the block returns box corners
// (out_x0, out_y0, out_x1, out_y1); with func high it returns one landmark
// point in out_x0 and out_y0 and zeros in out_x1 and out_y1. All results
// are signed Q6.14 and clamp to range, which raises saturated.
// The request passes through nine register stages, and the x and y lanes run
// side by side. The edge that accepts a request loads the first stage, and
// out_valid rises once the request has reached the last stage. Throughput is
// one request per cycle while out_stall is low.
// When out_stall holds the result, each stage that holds a request waits,
// while empty stages further up keep filling, so in_stall rises only once
// every stage is occupied. Nothing is dropped or repeated under stall.
// The configuration port (cfg_we, cfg_index, cfg_data) writes the center
// variance (index 0) or the size variance (index 1); other indexes are
// ignored. Write it only while the pipeline is empty.
// A synchronous reset empties the pipeline and restores both variances
// to 0.1 and 0.2.
`timescale 1ns / 1ps
`default_nettype none
`include "anchor_box_decoder_core_macros.svh"

module anchor_box_decoder_core
  import abd_pkg::*;
#(
  parameter int EXP_TABLE_BITS = ABD_EXP_TABLE_BITS
) (
  input  logic                     clk,
  input  logic                     rst,
  // Configuration write port.
  input  logic                     cfg_we,
  input  logic [ABD_CFG_IDX_W-1:0] cfg_index,
  input  logic [15:0]              cfg_data,
  // Request channel.
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic                     func,
  input  logic [15:0]              anchor_cx,
  input  logic [15:0]              anchor_cy,
  input  logic [15:0]              anchor_width,
  input  logic [15:0]              anchor_height,
  input  logic signed [15:0]       delta_x,
  input  logic signed [15:0]       delta_y,
  input  logic signed [15:0]       delta_w,
  input  logic signed [15:0]       delta_h,
  // Result channel.
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic signed [19:0]       out_x0,
  output logic signed [19:0]       out_y0,
  output logic signed [19:0]       out_x1,
  output logic signed [19:0]       out_y1,
  output logic                     saturated
);

  // Configuration registers, both unsigned Q0.16.
  logic [15:0] center_variance;
  logic [15:0] size_variance;

  always_ff @(posedge clk) begin
    if (rst) begin
      center_variance <= ABD_CENTER_VAR_RESET;
      size_variance   <= ABD_SIZE_VAR_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        ABD_REG_CENTER_VAR: center_variance <= cfg_data;
        ABD_REG_SIZE_VAR:   size_variance   <= cfg_data;
        default: ;
      endcase
    end
  end

  // Pipeline control. A stage may load when it is empty or when the stage
  // below it loads in the same cycle; the result stage frees up when the
  // receiver takes its request.
  logic [ABD_STAGES-1:0] stage_valid;
  logic [ABD_STAGES:0]   ready;
  abd_ctrl_t             ctrl;

  assign ready[ABD_STAGES] = ~out_stall;
  for (genvar k = 0; k < ABD_STAGES; k++) begin : g_ready
    assign ready[k] = ~stage_valid[k] | ready[k+1];
  end

  assign ctrl.load = ready[ABD_STAGES-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= '0;
    end else begin
      if (ready[0]) begin
        stage_valid[0] <= in_valid;
      end
      for (int k = 1; k < ABD_STAGES; k++) begin
        if (ready[k]) begin
          stage_valid[k] <= stage_valid[k-1];
        end
      end
    end
  end

  assign in_stall  = ~ready[0];
  assign out_valid = stage_valid[ABD_STAGES-1];

  // Datapath: one lane per axis.
  logic sat_x, sat_y;

  abd_lane #(
    .EXP_TABLE_BITS (EXP_TABLE_BITS)
  ) u_lane_x (
    .clk             (clk),
    .ctrl            (ctrl),
    .center_variance (center_variance),
    .size_variance   (size_variance),
    .func            (func),
    .center          (anchor_cx),
    .size            (anchor_width),
    .delta           (delta_x),
    .delta_size      (delta_w),
    .out_start       (out_x0),
    .out_end         (out_x1),
    .sat             (sat_x)
  );

  abd_lane #(
    .EXP_TABLE_BITS (EXP_TABLE_BITS)
  ) u_lane_y (
    .clk             (clk),
    .ctrl            (ctrl),
    .center_variance (center_variance),
    .size_variance   (size_variance),
    .func            (func),
    .center          (anchor_cy),
    .size            (anchor_height),
    .delta           (delta_y),
    .delta_size      (delta_h),
    .out_start       (out_y0),
    .out_end         (out_y1),
    .sat             (sat_y)
  );

  assign saturated = sat_x | sat_y;

  // Register writes, decoded once for the checks below.
  logic wr_center, wr_size;

  assign wr_center = cfg_we && (cfg_index == ABD_REG_CENTER_VAR);
  assign wr_size   = cfg_we && (cfg_index == ABD_REG_SIZE_VAR);

  // A stalled request port means every stage is full and the receiver stalls.
  `ABD_ASSERT_NOW(a_stall_means_full, in_stall, (&stage_valid) && out_stall, "stall with room")
  // A write to the center variance lands in the next cycle.
  `ABD_ASSERT_NEXT(a_cfg_center, wr_center, center_variance == $past(cfg_data), "center lost")
  // A write to the size variance lands in the next cycle.
  `ABD_ASSERT_NEXT(a_cfg_size, wr_size, size_variance == $past(cfg_data), "size lost")
  // Reset empties the pipeline.
  `ABD_ASSERT_NEXT_ALWAYS(a_reset_empty, rst, stage_valid == '0, "not empty after reset")

endmodule

`default_nettype wire

/* tb/tb_anchor_box_decoder_core.sv */
// Self-checking testbench for anchor_box_decoder_core: box and landmark decoding,
// variance registers, saturation and back-pressure on both channels.
// Depends on abd_pkg and the RTL of anchor_box_decoder_core; it reads no files.
`timescale 1ns / 1ps

module tb_anchor_box_decoder_core;
  import abd_pkg::*;

  // The exp table size of the instance; the local predictor builds its own table
  // of the same size.
  localparam int TB_EXP_BITS = ABD_EXP_TABLE_BITS;
  localparam int EXP_ENTRIES = 1 << TB_EXP_BITS;
  localparam int FRAC_BITS = 30 - TB_EXP_BITS;
  localparam longint FRAC_MASK = (longint'(1) << FRAC_BITS) - 1;
  localparam longint LOG2E_Q30 = 1549082005;
  localparam longint OUT_MAX = 524287;
  localparam longint OUT_MIN = -524288;

  // Operation codes of the func field.
  localparam logic FUNC_BOX = 1'b0;
  localparam logic FUNC_LANDMARK = 1'b1;

  // Register indexes the block does not decode; writes to them must be ignored.
  localparam logic [ABD_CFG_IDX_W-1:0] REG_SPARE_A = 2'd2;
  localparam logic [ABD_CFG_IDX_W-1:0] REG_SPARE_B = 2'd3;

  // Run shape and limits.
  localparam int RANDOM_PHASES = 8;
  localparam int ITEMS_PER_PHASE = 235;
  localparam int HOLD_AFTER = 900;
  localparam int HOLD_CYCLES = 150;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int MAX_REPORTS = 40;

  typedef struct {
    logic              func;
    logic [15:0]       cx;
    logic [15:0]       cy;
    logic [15:0]       aw;
    logic [15:0]       ah;
    logic signed [15:0] dx;
    logic signed [15:0] dy;
    logic signed [15:0] dw;
    logic signed [15:0] dh;
  } anchor_req_t;

  typedef struct {
    logic signed [19:0] x0;
    logic signed [19:0] y0;
    logic signed [19:0] x1;
    logic signed [19:0] y1;
    logic               sat;
  } corners_t;

  // One row of the directed table: the request, the variances it runs under,
  // and, for the rows whose answer is obvious, the result typed in by hand.
  typedef struct {
    anchor_req_t req;
    logic [15:0] cv;
    logic [15:0] sv;
    bit          known;
    corners_t    want;
  } stim_row_t;

  logic clk;
  logic rst;
  logic cfg_we;
  logic [ABD_CFG_IDX_W-1:0] cfg_index;
  logic [15:0] cfg_data;
  logic in_valid;
  logic in_stall;
  logic func;
  logic [15:0] anchor_cx;
  logic [15:0] anchor_cy;
  logic [15:0] anchor_width;
  logic [15:0] anchor_height;
  logic signed [15:0] delta_x;
  logic signed [15:0] delta_y;
  logic signed [15:0] delta_w;
  logic signed [15:0] delta_h;
  logic out_valid;
  logic out_stall;
  logic signed [19:0] out_x0;
  logic signed [19:0] out_y0;
  logic signed [19:0] out_x1;
  logic signed [19:0] out_y1;
  logic saturated;

  // Local copy of the variance registers as the block should hold them.
  logic [15:0] center_var_now;
  logic [15:0] size_var_now;

  // exp2 table of the predictor: entry i is 2^(i/N) in Q30.
  longint exp_tab [0:EXP_ENTRIES];

  // Decoded corners waiting for the block to produce them, oldest first.
  corners_t due_corners[$];
  stim_row_t stim_table[$];

  int error_count = 0;
  int cycle_count = 0;
  int requests_sent = 0;
  int box_requests = 0;
  int landmark_requests = 0;
  int results_seen = 0;
  int saturated_seen = 0;
  int settings_used = 0;
  int held_off_cycles = 0;
  bit sender_calm = 1'b0;

  anchor_box_decoder_core #(.EXP_TABLE_BITS(TB_EXP_BITS)) uut (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .func          (func),
    .anchor_cx     (anchor_cx),
    .anchor_cy     (anchor_cy),
    .anchor_width  (anchor_width),
    .anchor_height (anchor_height),
    .delta_x       (delta_x),
    .delta_y       (delta_y),
    .delta_w       (delta_w),
    .delta_h       (delta_h),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_x0        (out_x0),
    .out_y0        (out_y0),
    .out_x1        (out_x1),
    .out_y1        (out_y1),
    .saturated     (saturated)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Build the exp2 table the same way the hardware ROM is specified: the roots
  // are repeated floor square roots of two in Q30, and every entry multiplies
  // together the roots picked by its set bits, rounding half up after each step.
  initial begin : build_exp_table
    longint unsigned roots [0:TB_EXP_BITS];
    longint unsigned radicand;
    longint unsigned cand;
    longint unsigned acc;
    roots[0] = 64'd1 << 31;
    for (int k = 1; k <= TB_EXP_BITS; k++) begin
      radicand = roots[k-1] << 30;
      roots[k] = 64'd0;
      for (int b = 31; b >= 0; b--) begin
        cand = roots[k] | (64'd1 << b);
        if (cand * cand <= radicand) begin
          roots[k] = cand;
        end
      end
    end
    for (int i = 0; i <= EXP_ENTRIES; i++) begin
      acc = 64'd1 << 30;
      for (int j = 0; j <= TB_EXP_BITS; j++) begin
        if (((i >> j) & 1) == 1) begin
          acc = (acc * roots[TB_EXP_BITS - j] + (64'd1 << 29)) >> 30;
        end
      end
      exp_tab[i] = longint'(acc);
    end
  end

  // Arithmetic shift right that rounds half away from zero.
  function automatic longint round_away(input longint v, input int sh);
    longint half;
    half = longint'(1) <<< (sh - 1);
    if (v >= 0) return (v + half) >>> sh;
    return -((-v + half) >>> sh);
  endfunction

  // Center offset d * center_variance * size, taken from scale 2^-42 to Q16.
  function automatic longint center_offset(input logic signed [15:0] d,
                                           input logic [15:0] size);
    longint prod;
    prod = longint'(d) * longint'(center_var_now) * longint'(size);
    return round_away(prod, 26);
  endfunction

  // Half of size * exp(d * size_variance) in Q16. The exponent is turned into a
  // power of two, split into integer and fraction, and the fraction is looked up
  // with linear interpolation between neighboring table entries.
  function automatic longint half_extent(input logic signed [15:0] d,
                                         input logic [15:0] size);
    longint t;
    longint u;
    longint n;
    longint f;
    longint m;
    longint prod;
    int idx;
    int sh;
    t = longint'(d) * longint'(size_var_now);
    u = (t * LOG2E_Q30) >>> 28;
    n = u >>> 30;
    f = u - (n <<< 30);
    idx = int'(f >>> FRAC_BITS);
    m = exp_tab[idx] + (((exp_tab[idx + 1] - exp_tab[idx]) * (f & FRAC_MASK)) >>> FRAC_BITS);
    prod = longint'(size) * m;
    sh = 29 - int'(n);
    return (prod + (longint'(1) <<< (sh - 1))) >>> sh;
  endfunction

  // Q16 to Q14 with rounding, then clamp; the top bit of the result says the
  // value had to be clamped.
  function automatic logic [20:0] clamp_q14(input longint q16);
    longint v;
    v = round_away(q16, 2);
    if (v > OUT_MAX) return {1'b1, 20'h7FFFF};
    if (v < OUT_MIN) return {1'b1, 20'h80000};
    return {1'b0, v[19:0]};
  endfunction

  // Expected corners (or landmark point) for one request under the current
  // variance settings.
  function automatic corners_t decode_anchor(input anchor_req_t r);
    longint px;
    longint py;
    longint hw;
    longint hh;
    logic [20:0] c0;
    logic [20:0] c1;
    logic [20:0] c2;
    logic [20:0] c3;
    corners_t o;
    px = (longint'(r.cx) <<< 2) + center_offset(r.dx, r.aw);
    py = (longint'(r.cy) <<< 2) + center_offset(r.dy, r.ah);
    if (r.func == FUNC_BOX) begin
      hw = half_extent(r.dw, r.aw);
      hh = half_extent(r.dh, r.ah);
      c0 = clamp_q14(px - hw);
      c1 = clamp_q14(py - hh);
      c2 = clamp_q14(px + hw);
      c3 = clamp_q14(py + hh);
    end else begin
      // Landmark mode ignores the size deltas and leaves the far corner at zero.
      c0 = clamp_q14(px);
      c1 = clamp_q14(py);
      c2 = 21'd0;
      c3 = 21'd0;
    end
    o.x0 = c0[19:0];
    o.y0 = c1[19:0];
    o.x1 = c2[19:0];
    o.y1 = c3[19:0];
    o.sat = c0[20] | c1[20] | c2[20] | c3[20];
    return o;
  endfunction

  task automatic report_mismatch(input string what, input logic signed [31:0] got,
                                 input logic signed [31:0] want);
    error_count++;
    if (error_count <= MAX_REPORTS) begin
      $display("[%0t] mismatch on %s: got %0d, expected %0d", $time, what, got, want);
    end
  endtask

  task automatic add_row(input int cv, input int sv, input logic fn,
                         input int cx, input int cy, input int aw, input int ah,
                         input int dx, input int dy, input int dw, input int dh,
                         input bit known, input int x0, input int y0,
                         input int x1, input int y1, input bit sat);
    stim_row_t row;
    row.cv = 16'(cv);
    row.sv = 16'(sv);
    row.req.func = fn;
    row.req.cx = 16'(cx);
    row.req.cy = 16'(cy);
    row.req.aw = 16'(aw);
    row.req.ah = 16'(ah);
    row.req.dx = 16'(dx);
    row.req.dy = 16'(dy);
    row.req.dw = 16'(dw);
    row.req.dh = 16'(dh);
    row.known = known;
    row.want.x0 = 20'(x0);
    row.want.y0 = 20'(y0);
    row.want.x1 = 20'(x1);
    row.want.y1 = 20'(y1);
    row.want.sat = sat;
    stim_table = {stim_table, row};
  endtask

  // Gap before the next request: mostly none or short, now and then long, and
  // none at all while the sender is in a calm stretch.
  function automatic int sender_gap();
    int r;
    if (sender_calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 50);
  endfunction

  // Random request. Most are plausible detector outputs (anchors inside the
  // image, deltas of a few units); the rest are raw bits or field extremes.
  function automatic anchor_req_t random_request();
    anchor_req_t r;
    int pick;
    r.func = ($urandom_range(0, 99) < 70) ? FUNC_BOX : FUNC_LANDMARK;
    pick = $urandom_range(0, 99);
    if (pick < 20) begin
      r.cx = 16'($urandom);
      r.cy = 16'($urandom);
      r.aw = 16'($urandom);
      r.ah = 16'($urandom);
      r.dx = 16'($urandom);
      r.dy = 16'($urandom);
      r.dw = 16'($urandom);
      r.dh = 16'($urandom);
    end else if (pick < 27) begin
      r.cx = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
      r.cy = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
      r.aw = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
      r.ah = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
      r.dx = $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
      r.dy = $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
      r.dw = $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
      r.dh = $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
    end else begin
      r.cx = 16'($urandom_range(0, 16384));
      r.cy = 16'($urandom_range(0, 16384));
      r.aw = 16'($urandom_range(1, 8192));
      r.ah = 16'($urandom_range(1, 8192));
      r.dx = 16'(int'($urandom_range(0, 16384)) - 8192);
      r.dy = 16'(int'($urandom_range(0, 16384)) - 8192);
      r.dw = 16'(int'($urandom_range(0, 16384)) - 8192);
      r.dh = 16'(int'($urandom_range(0, 16384)) - 8192);
    end
    return r;
  endfunction

  // Offer one request and hold it until the block takes it. The expected
  // result is queued at the edge of acceptance. Valid is only lowered when a
  // gap is wanted, so a back-to-back request never toggles it within one step.
  task automatic offer(input anchor_req_t r, input bit known, input corners_t want);
    int gap;
    corners_t due;
    if (requests_sent % 64 == 0) sender_calm = ($urandom_range(0, 3) == 0);
    gap = sender_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    func <= r.func;
    anchor_cx <= r.cx;
    anchor_cy <= r.cy;
    anchor_width <= r.aw;
    anchor_height <= r.ah;
    delta_x <= r.dx;
    delta_y <= r.dy;
    delta_w <= r.dw;
    delta_h <= r.dh;
    do begin
      @(posedge clk);
      if (in_stall) held_off_cycles++;
    end while (in_stall);
    if (known) due = want;
    else due = decode_anchor(r);
    due_corners = {due_corners, due};
    requests_sent++;
    if (r.func == FUNC_BOX) box_requests++;
    else landmark_requests++;
  endtask

  // Stop sending and wait until every queued result has come back, then let
  // the clock run on so nothing is still in flight.
  task automatic settle();
    in_valid <= 1'b0;
    while (due_corners.size() != 0) @(posedge clk);
    repeat (ABD_STAGES + 4) @(posedge clk);
  endtask

  // One register write; the caller lowers cfg_we after its last write.
  task automatic write_cfg(input logic [ABD_CFG_IDX_W-1:0] idx, input logic [15:0] value);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    case (idx)
      ABD_REG_CENTER_VAR: center_var_now = value;
      ABD_REG_SIZE_VAR:   size_var_now = value;
      default: ;
    endcase
  endtask

  // Drain the block and load a new pair of variances. Optionally also write
  // the undecoded register indexes with junk, which must change nothing.
  task automatic apply_variances(input logic [15:0] cv, input logic [15:0] sv,
                                 input bit poke_spare);
    settle();
    write_cfg(ABD_REG_CENTER_VAR, cv);
    write_cfg(ABD_REG_SIZE_VAR, sv);
    if (poke_spare) begin
      write_cfg(REG_SPARE_A, 16'($urandom));
      write_cfg(REG_SPARE_B, 16'($urandom));
    end
    cfg_we <= 1'b0;
    settings_used++;
  endtask

  // Result side: check every accepted result against the oldest expectation,
  // and drive out_stall in random runs. Once, well into the random part, the
  // receiver holds off for a long stretch so that the pipeline fills and the
  // block has to stall its request side.
  initial begin : result_side
    int stall_left;
    int free_left;
    int r;
    bit long_hold_done;
    corners_t want;
    stall_left = 0;
    free_left = 0;
    long_hold_done = 1'b0;
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && out_valid === 1'b1 && !out_stall) begin
        results_seen++;
        if (saturated === 1'b1) saturated_seen++;
        if (due_corners.size() == 0) begin
          report_mismatch("result with nothing outstanding", 0, 0);
        end else begin
          want = due_corners.pop_front();
          if (out_x0 !== want.x0) report_mismatch("out_x0", out_x0, want.x0);
          if (out_y0 !== want.y0) report_mismatch("out_y0", out_y0, want.y0);
          if (out_x1 !== want.x1) report_mismatch("out_x1", out_x1, want.x1);
          if (out_y1 !== want.y1) report_mismatch("out_y1", out_y1, want.y1);
          if (saturated !== want.sat) report_mismatch("saturated", saturated, want.sat);
        end
      end
      if (stall_left > 0) begin
        stall_left--;
      end else if (free_left > 0) begin
        free_left--;
      end else if (!long_hold_done && results_seen >= HOLD_AFTER) begin
        long_hold_done = 1'b1;
        stall_left = HOLD_CYCLES;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 10) free_left = $urandom_range(50, 200);
        else if (r < 50) free_left = $urandom_range(0, 4);
        else if (r < 90) stall_left = $urandom_range(1, 3);
        else if (r < 98) stall_left = $urandom_range(4, 12);
        else stall_left = $urandom_range(20, 50);
      end
      out_stall <= (stall_left > 0);
    end
  end

  // Watchdog: a hung handshake ends the run as a failure.
  initial begin : watchdog
    while (cycle_count <= CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Timeout after %0d cycles with %0d results outstanding", cycle_count,
             due_corners.size());
    $display("DONE: errors detected");
    $finish;
  end

  // Request side: reset, the directed table, then random phases under a
  // series of variance settings that include both extremes of each register.
  initial begin : request_side
    anchor_req_t req;
    corners_t none;
    logic [15:0] cv;
    logic [15:0] sv;
    none = '{default: '0};
    rst <= 1'b1;
    cfg_we <= 1'b0;
    cfg_index <= ABD_REG_CENTER_VAR;
    cfg_data <= 16'd0;
    in_valid <= 1'b0;
    func <= FUNC_BOX;
    anchor_cx <= 16'd0;
    anchor_cy <= 16'd0;
    anchor_width <= 16'd0;
    anchor_height <= 16'd0;
    delta_x <= 16'sd0;
    delta_y <= 16'sd0;
    delta_w <= 16'sd0;
    delta_h <= 16'sd0;
    center_var_now = ABD_CENTER_VAR_RESET;
    size_var_now = ABD_SIZE_VAR_RESET;

    // Directed table. Columns: center and size variance, func, cx, cy, w, h,
    // dx, dy, dw, dh, then the hand-typed result where there is one.
    // All zeros under the reset variances must give all zeros.
    add_row(6554, 13107, FUNC_BOX, 0, 0, 0, 0, 0, 0, 0, 0, 1, 0, 0, 0, 0, 0);
    add_row(6554, 13107, FUNC_LANDMARK, 0, 0, 0, 0, 0, 0, 0, 0, 1, 0, 0, 0, 0, 0);
    // Zero-size anchor: the landmark is the center itself, whatever the deltas.
    add_row(6554, 13107, FUNC_LANDMARK, 65535, 65535, 0, 0, 32767, 32767, -32768, 32767,
            1, 65535, 65535, 0, 0, 0);
    add_row(6554, 13107, FUNC_BOX, 16384, 8192, 4096, 8192, 1229, -2048, 819, -4096,
            0, 0, 0, 0, 0, 0);
    // Landmark with extreme size deltas, which must be ignored.
    add_row(6554, 13107, FUNC_LANDMARK, 20000, 30000, 5000, 6000, 4096, -4096, 32767, -32768,
            0, 0, 0, 0, 0, 0);
    add_row(6554, 13107, FUNC_BOX, 65535, 65535, 65535, 65535, 32767, 32767, 32767, 32767,
            0, 0, 0, 0, 0, 0);
    add_row(6554, 13107, FUNC_BOX, 0, 0, 65535, 65535, -32768, -32768, -32768, -32768,
            0, 0, 0, 0, 0, 0);
    // Huge box around the origin: both corners clamp to the ends of the range.
    add_row(65535, 65535, FUNC_BOX, 0, 0, 65535, 65535, 0, 0, 32767, 32767,
            1, -524288, -524288, 524287, 524287, 1);
    add_row(65535, 65535, FUNC_BOX, 65535, 0, 1, 65535, 32767, -32768, -32768, 1,
            0, 0, 0, 0, 0, 0);
    // Landmark pushed past the top of the range clamps and flags it.
    add_row(65535, 65535, FUNC_LANDMARK, 65535, 0, 65535, 0, 32767, 0, 0, 0,
            1, 524287, 0, 0, 0, 1);
    add_row(65535, 65535, FUNC_LANDMARK, 0, 65535, 65535, 65535, -32768, 32767, 0, 0,
            0, 0, 0, 0, 0, 0);
    // Zero size variance: exp is exactly one, so the box keeps the anchor size.
    add_row(0, 0, FUNC_BOX, 8192, 8192, 4096, 4096, 0, 0, 32767, -32768,
            1, 6144, 6144, 10240, 10240, 0);
    add_row(0, 0, FUNC_BOX, 12345, 54321, 65535, 1, 32767, -32768, -1, 1,
            0, 0, 0, 0, 0, 0);
    add_row(0, 65535, FUNC_BOX, 40000, 1000, 30000, 200, -1, 1, 4096, -4096,
            0, 0, 0, 0, 0, 0);
    add_row(65535, 0, FUNC_LANDMARK, 1, 2, 3, 4, -1, -32768, 0, 0, 0, 0, 0, 0, 0, 0);
    add_row(65535, 0, FUNC_BOX, 32768, 32768, 65535, 32768, -32768, 32767, 0, 0,
            0, 0, 0, 0, 0, 0);
    add_row(1, 1, FUNC_BOX, 8192, 8192, 16384, 16384, 32767, -32768, 32767, -32768,
            0, 0, 0, 0, 0, 0);
    add_row(1, 1, FUNC_LANDMARK, 43690, 21845, 21845, 43690, 21845, -21846, 0, 0,
            0, 0, 0, 0, 0, 0);

    repeat (2) @(posedge clk);
    rst <= 1'b0;
    settings_used = 1;

    // Directed part: a register change drains the block first.
    foreach (stim_table[i]) begin
      if (stim_table[i].cv != center_var_now || stim_table[i].sv != size_var_now) begin
        apply_variances(stim_table[i].cv, stim_table[i].sv, 1'b0);
      end
      offer(stim_table[i].req, stim_table[i].known, stim_table[i].want);
    end

    // Random part: the reset values written back explicitly, each corner of
    // the register space, then random settings.
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      case (p)
        0: begin cv = ABD_CENTER_VAR_RESET; sv = ABD_SIZE_VAR_RESET; end
        1: begin cv = 16'd0; sv = 16'hFFFF; end
        2: begin cv = 16'hFFFF; sv = 16'd0; end
        3: begin cv = 16'hFFFF; sv = 16'hFFFF; end
        4: begin cv = 16'd0; sv = 16'd0; end
        5: begin
          cv = 16'($urandom_range(3000, 20000));
          sv = 16'($urandom_range(6000, 30000));
        end
        default: begin cv = 16'($urandom); sv = 16'($urandom); end
      endcase
      apply_variances(cv, sv, (p == 0) || (p == RANDOM_PHASES - 1));
      repeat (ITEMS_PER_PHASE) begin
        req = random_request();
        offer(req, 1'b0, none);
      end
    end

    settle();
    $display("Checked %0d results from %0d requests (%0d boxes, %0d landmarks),",
             results_seen, requests_sent, box_requests, landmark_requests);
    $display("%0d saturated, under %0d variance settings; request side held off %0d cycles.",
             saturated_seen, settings_used, held_off_cycles);
    if (error_count == 0 && due_corners.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

/* filelist.f */
+incdir+rtl
rtl/abd_pkg.sv
rtl/abd_lane.sv
rtl/anchor_box_decoder_core.sv
tb/tb_anchor_box_decoder_core.sv
